// ----- design/frs_pkg.sv -----
package frs_pkg;

    // ring geometry and field widths
    localparam int FRAMES      = 3;
    localparam int MAX_SLOTS   = 4096;
    localparam int CNT_W       = 13;
    localparam int SLOT_W      = 12;
    localparam int STRIDE_W    = 13;
    localparam int ADDR_W      = 64;
    localparam int OFF_W       = SLOT_W + STRIDE_W;
    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int CFG_IDX_W   = 2;

    // command queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // action codes on the input beat
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = CFG_IDX_W'(0),
        CFG_STRIDE   = CFG_IDX_W'(1),
        CFG_CPU_BASE = CFG_IDX_W'(2),
        CFG_GPU_BASE = CFG_IDX_W'(3)
    } t_cfg_idx;

    // classified command kinds
    typedef enum logic {
        K_ALLOC,
        K_ADVANCE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CNT_W-1:0]  count;
    } t_cmd;

    // result record carried down the address pipeline
    typedef struct packed {
        logic              ok;
        logic              addr_ok;
        logic [SLOT_W-1:0] first;
        logic [CNT_W-1:0]  used;
    } t_res;

endpackage

// ----- design/frs_front.sv -----
module frs_front import frs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    t_cmd              w_cmd;
    logic              w_push;

    // classify the incoming beat, count is dropped on a frame advance
    always_comb begin
        case (i_action)
            ACT_ADVANCE: begin
                w_cmd.kind  = K_ADVANCE;
                w_cmd.count = '0;
            end
            default: begin
                w_cmd.kind  = K_ALLOC;
                w_cmd.count = i_count;
            end
        endcase
    end

    assign o_in_ready  = (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ----- design/frs_mod.sv -----
module frs_mod import frs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_x,
    input  logic [CNT_W-1:0]  i_cap,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(CNT_W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_CHECK,
        M_ITER
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_x;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_done;
    logic [SLOT_W-1:0] r_out;

    logic [CNT_W:0]    w_sub1;
    logic [CNT_W:0]    w_sub2;
    logic [CNT_W-1:0]  w_shift;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W-1:0]  w_next_rem;

    // fast path: value already below one or two capacities
    assign w_sub1 = {1'b0, r_x} - {1'b0, i_cap};
    assign w_sub2 = {1'b0, w_sub1[CNT_W-1:0]} - {1'b0, i_cap};

    // restoring step, one dividend bit per cycle
    assign w_shift    = {r_rem[CNT_W-2:0], r_x[CNT_W-1]};
    assign w_trial    = {1'b0, w_shift} - {1'b0, i_cap};
    assign w_next_rem = w_trial[CNT_W] ? w_shift : w_trial[CNT_W-1:0];

    assign o_done = r_done;
    assign o_rem  = r_out;

    // sequencer, a new start always restarts the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x     <= i_x;
                r_state <= M_CHECK;
            end else begin
                case (r_state)
                    M_CHECK: begin
                        if (w_sub1[CNT_W]) begin
                            r_out   <= r_x[SLOT_W-1:0];
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end else if (w_sub2[CNT_W]) begin
                            r_out   <= w_sub1[SLOT_W-1:0];
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end else begin
                            r_rem   <= '0;
                            r_step  <= STEP_W'(CNT_W - 1);
                            r_state <= M_ITER;
                        end
                    end
                    M_ITER: begin
                        r_rem <= w_next_rem;
                        r_x   <= {r_x[CNT_W-2:0], 1'b0};
                        if (r_step == '0) begin
                            r_out   <= w_next_rem[SLOT_W-1:0];
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end else begin
                            r_step <= r_step - 1'b1;
                        end
                    end
                    default: begin
                        r_state <= M_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ----- design/frs_back.sv -----
module frs_back import frs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    input  logic [CNT_W-1:0]    i_cap,
    input  logic                i_cap_wr,
    input  logic [STRIDE_W-1:0] i_stride,
    input  logic [ADDR_W-1:0]   i_cpu_base,
    input  logic [ADDR_W-1:0]   i_gpu_base,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_ok,
    output logic [SLOT_W-1:0]   o_first_slot,
    output logic [ADDR_W-1:0]   o_cpu_address,
    output logic [ADDR_W-1:0]   o_gpu_address,
    output logic [CNT_W-1:0]    o_used_slots
);

    function automatic logic [FRAME_W-1:0] f_next(input logic [FRAME_W-1:0] f);
        logic [FRAME_W-1:0] n;
        if (f == FRAME_W'(FRAMES - 1)) begin
            n = '0;
        end else begin
            n = f + 1'b1;
        end
        return n;
    endfunction

    // ring state
    logic [CNT_W-1:0]   r_count [FRAMES];
    logic [SLOT_W-1:0]  r_start [FRAMES];
    logic [SLOT_W-1:0]  r_tail;
    logic [SLOT_W-1:0]  r_head;
    logic               r_head_ok;
    logic [FRAME_W-1:0] r_cur;
    logic [CNT_W-1:0]   r_used;

    // address pipeline
    logic               r_e_valid;
    t_res               r_e;
    logic               r_p_valid;
    t_res               r_p;
    logic [OFF_W-1:0]   r_p_off;
    logic               r_o_valid;
    t_res               r_o;
    logic [ADDR_W-1:0]  r_o_cpu;
    logic [ADDR_W-1:0]  r_o_gpu;

    logic               w_o_ready;
    logic               w_p_ready;
    logic               w_e_ready;
    logic               w_fire;
    logic               w_adv;

    logic [CNT_W-1:0]   w_free;
    logic [CNT_W-1:0]   w_remain;
    logic               w_fit_free;
    logic               w_need_wrap;
    logic               w_wrap_ok;
    logic               w_grant;
    logic [CNT_W-1:0]   w_delta;
    logic [SLOT_W-1:0]  w_first;
    logic [CNT_W:0]     w_hsum;
    logic [CNT_W:0]     w_hwrap;
    logic [SLOT_W-1:0]  w_new_head;
    logic [CNT_W-1:0]   w_used_alloc;

    logic [FRAME_W-1:0] w_nxt;
    logic [FRAME_W-1:0] w_nxt2;
    logic [CNT_W-1:0]   w_used_adv;
    logic [CNT_W-1:0]   w_x_adv;

    logic               w_mod_start;
    logic [CNT_W-1:0]   w_mod_x;
    logic               w_mod_done;
    logic [SLOT_W-1:0]  w_mod_rem;
    t_res               w_res;

    // stage handshakes, back to front
    assign w_o_ready = !r_o_valid || i_out_ready;
    assign w_p_ready = !r_p_valid || w_o_ready;
    assign w_e_ready = !r_e_valid || w_p_ready;
    assign w_fire    = i_cmd_valid && r_head_ok && w_e_ready;
    assign w_adv     = (i_cmd.kind == K_ADVANCE);
    assign o_cmd_pop = w_fire;

    // allocation: free space, wrap check and padding
    assign w_free      = (r_used >= i_cap) ? '0 : i_cap - r_used;
    assign w_remain    = i_cap - CNT_W'(r_head);
    assign w_fit_free  = (i_cmd.count <= w_free);
    assign w_need_wrap = ((r_head > r_tail) || (r_used == '0)) && (w_remain < i_cmd.count);
    assign w_wrap_ok   = ((CNT_W+1)'(w_remain) + (CNT_W+1)'(i_cmd.count))
                         <= (CNT_W+1)'(w_free);
    assign w_grant     = w_fit_free && (!w_need_wrap || w_wrap_ok);
    assign w_delta     = (w_need_wrap ? w_remain : '0) + i_cmd.count;
    assign w_first     = w_need_wrap ? '0 : r_head;

    // running head after a grant, one conditional subtract
    assign w_hsum       = (CNT_W+1)'(r_head) + (CNT_W+1)'(w_delta);
    assign w_hwrap      = w_hsum - (CNT_W+1)'(i_cap);
    assign w_new_head   = (w_hsum >= (CNT_W+1)'(i_cap)) ? w_hwrap[SLOT_W-1:0]
                                                        : w_hsum[SLOT_W-1:0];
    assign w_used_alloc = r_used + w_delta;

    // frame advance: retire the oldest frame, tail moves to the one after it
    assign w_nxt      = f_next(r_cur);
    assign w_nxt2     = f_next(w_nxt);
    assign w_used_adv = r_used - r_count[w_nxt];
    assign w_x_adv    = CNT_W'(r_start[w_nxt2]) + w_used_adv;

    // head recompute after an advance or a capacity change
    assign w_mod_start = (w_fire && w_adv) || i_cap_wr;
    assign w_mod_x     = i_cap_wr ? CNT_W'(r_tail) + r_used : w_x_adv;

    frs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_x     (w_mod_x),
        .i_cap   (i_cap),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // result record of the executed command
    always_comb begin
        w_res.ok      = w_adv || w_grant;
        w_res.addr_ok = !w_adv && w_grant;
        w_res.first   = (!w_adv && w_grant) ? w_first : '0;
        if (w_adv) begin
            w_res.used = w_used_adv;
        end else if (w_grant) begin
            w_res.used = w_used_alloc;
        end else begin
            w_res.used = r_used;
        end
    end

    // ring state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) begin
                r_count[i] <= '0;
                r_start[i] <= '0;
            end
            r_tail    <= '0;
            r_head    <= '0;
            r_head_ok <= 1'b1;
            r_cur     <= '0;
            r_used    <= '0;
        end else begin
            if (w_mod_done) begin
                r_head    <= w_mod_rem;
                r_head_ok <= 1'b1;
            end
            if (i_cap_wr) begin
                r_head_ok <= 1'b0;
            end
            if (w_fire) begin
                case (i_cmd.kind)
                    K_ADVANCE: begin
                        r_cur          <= w_nxt;
                        r_start[w_nxt] <= r_head;
                        r_count[w_nxt] <= '0;
                        r_used         <= w_used_adv;
                        r_tail         <= r_start[w_nxt2];
                        r_head_ok      <= 1'b0;
                    end
                    default: begin
                        if (w_grant) begin
                            r_count[r_cur] <= r_count[r_cur] + w_delta;
                            r_used         <= w_used_alloc;
                            r_head         <= w_new_head;
                        end
                    end
                endcase
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_e_ready) begin
                r_e_valid <= w_fire;
            end
            if (w_p_ready) begin
                r_p_valid <= r_e_valid;
            end
            if (w_o_ready) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    // pipeline payload: record, slot offset, base add
    always_ff @(posedge i_clk) begin
        if (w_e_ready) begin
            r_e <= w_res;
        end
        if (w_p_ready) begin
            r_p     <= r_e;
            r_p_off <= OFF_W'(r_e.first) * OFF_W'(i_stride);
        end
        if (w_o_ready) begin
            r_o     <= r_p;
            r_o_cpu <= r_p.addr_ok ? i_cpu_base + ADDR_W'(r_p_off) : '0;
            r_o_gpu <= r_p.addr_ok ? i_gpu_base + ADDR_W'(r_p_off) : '0;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_ok          = r_o.ok;
    assign o_first_slot  = r_o.first;
    assign o_cpu_address = r_o_cpu;
    assign o_gpu_address = r_o_gpu;
    assign o_used_slots  = r_o.used;

endmodule

// ----- design/frame_ring_slot_allocator_top.sv -----
// channel   direction  beat
// in        in         i_action, i_count
// out       out        o_ok, o_first_slot, o_cpu_address, o_gpu_address, o_used_slots
// cfg       in         i_cfg_index, i_cfg_data (always ready)
//
// allocate beats execute one per cycle unless the ring head is pending or the output stalls
// a frame advance or a capacity write recomputes the ring head in a shared modulo unit:
// the next command waits for the unit, longer when the head is at least twice the capacity
// a 4-entry command queue keeps taking beats until full while the back end or output stalls
// reset is synchronous active low and clears ring state, queue and pipeline valids
module frame_ring_slot_allocator_top import frs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [CNT_W-1:0]     i_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_ok,
    output logic [SLOT_W-1:0]    o_first_slot,
    output logic [ADDR_W-1:0]    o_cpu_address,
    output logic [ADDR_W-1:0]    o_gpu_address,
    output logic [CNT_W-1:0]     o_used_slots,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    logic [CNT_W-1:0]    r_capacity;
    logic [STRIDE_W-1:0] r_stride;
    logic [ADDR_W-1:0]   r_cpu_base;
    logic [ADDR_W-1:0]   r_gpu_base;
    logic [CNT_W-1:0]    w_cap_eff;
    logic                w_cap_wr;
    logic                w_cmd_valid;
    t_cmd                w_cmd;
    logic                w_cmd_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cap_wr    = i_cfg_valid && (t_cfg_idx'(i_cfg_index) == CFG_CAPACITY);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(MAX_SLOTS);
            r_stride   <= STRIDE_W'(32);
            r_cpu_base <= '0;
            r_gpu_base <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CAPACITY: r_capacity <= i_cfg_data[CNT_W-1:0];
                CFG_STRIDE:   r_stride   <= i_cfg_data[STRIDE_W-1:0];
                CFG_CPU_BASE: r_cpu_base <= i_cfg_data;
                CFG_GPU_BASE: r_gpu_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capacity clamped to 1..MAX_SLOTS
    always_comb begin
        if (r_capacity == '0) begin
            w_cap_eff = CNT_W'(1);
        end else if (r_capacity > CNT_W'(MAX_SLOTS)) begin
            w_cap_eff = CNT_W'(MAX_SLOTS);
        end else begin
            w_cap_eff = r_capacity;
        end
    end

    frs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_count     (i_count),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    frs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .i_cap         (w_cap_eff),
        .i_cap_wr      (w_cap_wr),
        .i_stride      (r_stride),
        .i_cpu_base    (r_cpu_base),
        .i_gpu_base    (r_gpu_base),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_first_slot  (o_first_slot),
        .o_cpu_address (o_cpu_address),
        .o_gpu_address (o_gpu_address),
        .o_used_slots  (o_used_slots)
    );

    // ring occupancy never exceeds the largest ring
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_used_slots <= CNT_W'(MAX_SLOTS)))
        else $error("used slot count above ring size");

    // a refused beat carries no slot and no addresses
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |->
            (o_first_slot == '0) && (o_cpu_address == '0) && (o_gpu_address == '0))
        else $error("refused beat with nonzero slot or address");

    // a granted run starts inside the ring
    a_first_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ok) |-> (CNT_W'(o_first_slot) < w_cap_eff))
        else $error("first slot outside capacity");

    // a command never leaves the queue while none is waiting
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from empty queue");

endmodule

// ----- sim/tb_top.sv -----
module tb_top import frs_pkg::*;;

    localparam int STUCK_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 20;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one result beat as seen on the output channel
    typedef struct {
        logic              ok;
        logic [SLOT_W-1:0] first;
        logic [ADDR_W-1:0] cpu_addr;
        logic [ADDR_W-1:0] gpu_addr;
        logic [CNT_W-1:0]  used;
    } grant_t;

    // ring bookkeeping and the queue of predicted grants
    class grant_checker;
        int unsigned capacity_reg;
        int unsigned stride_reg;
        logic [ADDR_W-1:0] cpu_base;
        logic [ADDR_W-1:0] gpu_base;
        int unsigned slots_held [FRAMES];
        int unsigned frame_start [FRAMES];
        int unsigned tail;
        int unsigned cur_frame;
        grant_t pending_grants [$];
        int mismatches;

        function new();
            capacity_reg = 4096;
            stride_reg   = 32;
            cpu_base     = '0;
            gpu_base     = '0;
            for (int f = 0; f < FRAMES; f++) begin
                slots_held[f] = 0;
                frame_start[f] = 0;
            end
            tail       = 0;
            cur_frame  = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [ADDR_W-1:0] data);
            case (idx)
                CFG_CAPACITY: capacity_reg = int'(data[CNT_W-1:0]);
                CFG_STRIDE:   stride_reg = int'(data[STRIDE_W-1:0]);
                CFG_CPU_BASE: cpu_base = data;
                CFG_GPU_BASE: gpu_base = data;
                default: ;
            endcase
        endfunction

        // zero acts as one, anything above the ring maximum is clamped
        function int unsigned ring_size();
            if (capacity_reg == 0) return 1;
            if (capacity_reg > MAX_SLOTS) return MAX_SLOTS;
            return capacity_reg;
        endfunction

        function int unsigned ring_used();
            int unsigned s;
            s = 0;
            for (int f = 0; f < FRAMES; f++) s += slots_held[f];
            return s;
        endfunction

        // advance the ring for one accepted request and queue its grant
        function void note_request(logic action, logic [CNT_W-1:0] count);
            int unsigned cap, used, n, free_slots, head, nxt, remain, pad;
            bit fits;
            logic [ADDR_W-1:0] off;
            grant_t g;
            cap = ring_size();
            used = ring_used();
            n = count;
            g.ok = 1'b0;
            g.first = '0;
            g.cpu_addr = '0;
            g.gpu_addr = '0;
            if (action == ACT_ADVANCE) begin
                // new frame starts at the head, tail moves to the oldest live frame
                head = (tail + used) % cap;
                nxt = (cur_frame + 1) % FRAMES;
                cur_frame = nxt;
                frame_start[nxt] = head;
                slots_held[nxt] = 0;
                tail = frame_start[(nxt + 1) % FRAMES];
                g.ok = 1'b1;
            end else begin
                free_slots = (used >= cap) ? 0 : cap - used;
                if (n <= free_slots) begin
                    head = (tail + used) % cap;
                    pad = 0;
                    fits = 1'b1;
                    // run crossing the ring end restarts at zero, the rest is padding
                    if (head > tail || used == 0) begin
                        remain = cap - head;
                        if (remain < n) begin
                            if (remain > free_slots || free_slots - remain < n) begin
                                fits = 1'b0;
                            end else begin
                                pad = remain;
                                head = 0;
                            end
                        end
                    end
                    if (fits) begin
                        slots_held[cur_frame] += pad + n;
                        off = ADDR_W'(head) * ADDR_W'(stride_reg);
                        g.ok = 1'b1;
                        g.first = SLOT_W'(head);
                        g.cpu_addr = cpu_base + off;
                        g.gpu_addr = gpu_base + off;
                    end
                end
            end
            g.used = CNT_W'(ring_used());
            pending_grants.push_back(g);
        endfunction

        task report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
            $display("mismatch %s: got %0h, predicted %0h at %0t", what, got, want, $time);
            mismatches++;
        endtask

        task check_grant(grant_t got);
            grant_t want;
            if (pending_grants.size() == 0) begin
                report("result with no pending request", 0, 0);
                return;
            end
            want = pending_grants.pop_front();
            if (got.ok !== want.ok) report("ok", got.ok, want.ok);
            if (got.first !== want.first) report("first_slot", got.first, want.first);
            if (got.cpu_addr !== want.cpu_addr) report("cpu_address", got.cpu_addr, want.cpu_addr);
            if (got.gpu_addr !== want.gpu_addr) report("gpu_address", got.gpu_addr, want.gpu_addr);
            if (got.used !== want.used) report("used_slots", got.used, want.used);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_action;
    logic [CNT_W-1:0]     i_count;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_ok;
    logic [SLOT_W-1:0]    o_first_slot;
    logic [ADDR_W-1:0]    o_cpu_address;
    logic [ADDR_W-1:0]    o_gpu_address;
    logic [CNT_W-1:0]     o_used_slots;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    grant_checker ledger = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int stuck_cycles = 0;

    frame_ring_slot_allocator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_count       (i_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_first_slot  (o_first_slot),
        .o_cpu_address (o_cpu_address),
        .o_gpu_address (o_gpu_address),
        .o_used_slots  (o_used_slots),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    // beat monitor, checker and watchdog
    always @(posedge i_clk) begin
        grant_t seen;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                ledger.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                ledger.note_request(i_action, i_count);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                seen.ok = o_ok;
                seen.first = o_first_slot;
                seen.cpu_addr = o_cpu_address;
                seen.gpu_addr = o_gpu_address;
                seen.used = o_used_slots;
                ledger.check_grant(seen);
                moved = 1'b1;
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 72; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 72; end
            default:       begin gap_pct = 31; stall_pct = 31; end
        endcase
    endtask

    // one request beat, with optional idle cycles ahead of it
    task automatic send_request(logic act, int unsigned cnt);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action = act;
        i_count = CNT_W'(cnt);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_config(t_cfg_idx idx, logic [ADDR_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // hold the sender until every predicted grant has come back
    task automatic drain();
        i_in_valid = 1'b0;
        while (ledger.pending_grants.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly allocations sized to the ring, some advances and full-range noise
    task automatic run_phase(idle_mode_t mode, int items);
        int unsigned pick, cap, used;
        set_idling(mode);
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(0, 99);
            cap = ledger.ring_size();
            used = ledger.ring_used();
            if (k == items / 2) drain();
            if (pick < 14)
                send_request(ACT_ADVANCE, $urandom_range(0, 8191));
            else if (pick < 20)
                send_request(ACT_ALLOC, $urandom_range(0, 8191));
            else if (pick < 26)
                send_request(ACT_ALLOC, (used >= cap) ? $urandom_range(0, 1) : cap - used);
            else
                send_request(ACT_ALLOC, $urandom_range(0, (cap < 4) ? cap : cap / 4));
        end
    endtask

    initial begin
        int unsigned cap_plan [8];
        int unsigned stride_plan [8];
        cap_plan = '{4096, 9, 8191, 1, 600, 0, 37, 4096};
        stride_plan = '{1, 4096, 8191, 32, 1, 4096, 8191, 7};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_ALLOC;
        i_count = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAPACITY;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: zero count, small run, refusals, fill the whole ring
        set_idling(IDLE_NONE);
        send_request(ACT_ALLOC, 0);
        send_request(ACT_ALLOC, 1);
        send_request(ACT_ALLOC, 4096);
        send_request(ACT_ALLOC, 8191);
        send_request(ACT_ADVANCE, 8191);
        send_request(ACT_ALLOC, 4095);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ADVANCE, 0);
        drain();

        // small ring below the held slots, then wrap of an empty ring with moved tail
        write_config(CFG_CAPACITY, ADDR_W'(10));
        write_config(CFG_STRIDE, ADDR_W'(4096));
        write_config(CFG_CPU_BASE, '1);
        write_config(CFG_GPU_BASE, 64'h8000_0000_0000_0000);
        send_request(ACT_ALLOC, 1);
        send_request(ACT_ALLOC, 0);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ALLOC, 7);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ADVANCE, 0);
        send_request(ACT_ALLOC, 5);
        send_request(ACT_ALLOC, 3);
        send_request(ACT_ALLOC, 2);
        drain();

        // zero capacity acts as a single slot
        write_config(CFG_CAPACITY, ADDR_W'(0));
        send_request(ACT_ALLOC, 1);
        send_request(ACT_ADVANCE, 0);
        drain();

        // random phases over ring sizes, strides, bases and idling patterns
        for (int p = 0; p < 8; p++) begin
            write_config(CFG_CAPACITY, ADDR_W'(cap_plan[p]));
            write_config(CFG_STRIDE, ADDR_W'(stride_plan[p]));
            write_config(CFG_CPU_BASE, (p == 1) ? '1 : {$urandom(), $urandom()});
            write_config(CFG_GPU_BASE, (p == 3) ? '0 : {$urandom(), $urandom()});
            run_phase(idle_mode_t'(p % 4), 200);
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
